### src/frc_pkg.sv
package frc_pkg;

  localparam logic [1:0] REQ_PUSH    = 2'd0;
  localparam logic [1:0] REQ_POP     = 2'd1;
  localparam logic [1:0] REQ_RELEASE = 2'd2;
  localparam logic [1:0] REQ_CLEAR   = 2'd3;

  localparam logic signed [3:0] NO_POOL_INDEX = -4'sd1;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [63:0]       frame_handle;
    logic [62:0]       capture_time;
    logic [62:0]       source_time;
    logic [63:0]       fence_value;
    logic              needs_sync;
    logic signed [3:0] pool_index;
  } req_t;

  typedef struct packed {
    logic              pop_valid;
    logic [63:0]       out_handle;
    logic [62:0]       out_capture_time;
    logic [62:0]       out_source_time;
    logic [63:0]       out_fence;
    logic              out_sync;
    logic signed [3:0] out_pool_index;
    logic [63:0]       out_generation;
    logic [7:0]        inflight_mask;
    logic [2:0]        entry_count;
    logic              dropped_oldest;
  } rsp_t;

  typedef struct packed {
    logic [63:0]       handle;
    logic [62:0]       capture_time;
    logic [62:0]       source_time;
    logic [63:0]       fence;
    logic              sync;
    logic signed [3:0] pool_index;
    logic [63:0]       generation;
  } entry_t;

endpackage

### src/frc_store.sv
module frc_store #(
  parameter int RING_DEPTH = 4,
  parameter int PW = 2
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [PW-1:0]     wr_addr,
  input  frc_pkg::entry_t   wr_entry,
  input  logic [PW-1:0]     rd_addr,
  output frc_pkg::entry_t   head
);

  frc_pkg::entry_t mem [RING_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
  end

  // The head register always holds the oldest entry; a write to that same slot is forwarded.
  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == rd_addr)) begin
      head <= wr_entry;
    end else begin
      head <= mem[rd_addr];
    end
  end

endmodule

### src/frc_ctrl.sv
module frc_ctrl #(
  parameter int RING_DEPTH = 4,
  parameter int POOL_SLOTS = 8,
  parameter int PW = 2,
  parameter int CW = 3
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  frc_pkg::req_t     item,
  input  frc_pkg::entry_t   head,
  input  logic [63:0]       generation,
  output frc_pkg::rsp_t     result,
  output logic              wr_en,
  output logic [PW-1:0]     wr_addr,
  output frc_pkg::entry_t   wr_entry,
  output logic [PW-1:0]     rd_addr
);

  logic [PW-1:0]         write_pointer, write_pointer_next;
  logic [PW-1:0]         read_pointer, read_pointer_next;
  logic [CW-1:0]         fill_count, fill_count_next;
  logic [POOL_SLOTS-1:0] busy_mask, busy_mask_next;
  logic [POOL_SLOTS-1:0] item_bit, head_bit;
  logic                  push_ok;
  logic                  full;
  logic [POOL_SLOTS+7:0] mask_ext;
  logic [CW+2:0]         count_ext;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    logic [PW-1:0] r;
    if (p == PW'(RING_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PW'(1);
    end
    return r;
  endfunction

  always_comb begin
    for (int i = 0; i < POOL_SLOTS; i++) begin
      item_bit[i] = !item.pool_index[3] && ({2'b00, item.pool_index[2:0]} == 5'(i));
      head_bit[i] = !head.pool_index[3] && ({2'b00, head.pool_index[2:0]} == 5'(i));
    end
  end

  assign push_ok = (item.req_type == frc_pkg::REQ_PUSH) && (item.frame_handle != 64'd0);
  assign full    = (fill_count >= CW'(RING_DEPTH));

  always_comb begin
    write_pointer_next = write_pointer;
    read_pointer_next  = read_pointer;
    fill_count_next    = fill_count;
    busy_mask_next     = busy_mask;
    result             = '0;
    result.out_pool_index = frc_pkg::NO_POOL_INDEX;
    unique case (item.req_type)
      frc_pkg::REQ_PUSH: begin
        if (push_ok) begin
          if (full) begin
            busy_mask_next    = busy_mask & ~head_bit;
            read_pointer_next = ptr_inc(read_pointer);
            result.dropped_oldest = 1'b1;
          end else begin
            fill_count_next = fill_count + CW'(1);
          end
          busy_mask_next     = busy_mask_next | item_bit;
          write_pointer_next = ptr_inc(write_pointer);
        end
      end
      frc_pkg::REQ_POP: begin
        if (fill_count != '0) begin
          read_pointer_next       = ptr_inc(read_pointer);
          fill_count_next         = fill_count - CW'(1);
          result.pop_valid        = 1'b1;
          result.out_handle       = head.handle;
          result.out_capture_time = head.capture_time;
          result.out_source_time  = head.source_time;
          result.out_fence        = head.fence;
          result.out_sync         = head.sync;
          result.out_pool_index   = head.pool_index;
          result.out_generation   = head.generation;
        end
      end
      frc_pkg::REQ_RELEASE: begin
        busy_mask_next = busy_mask & ~item_bit;
      end
      frc_pkg::REQ_CLEAR: begin
        write_pointer_next = '0;
        read_pointer_next  = '0;
        fill_count_next    = '0;
        busy_mask_next     = '0;
      end
      default: begin
      end
    endcase
    mask_ext             = {8'd0, busy_mask_next};
    count_ext            = {3'd0, fill_count_next};
    result.inflight_mask = mask_ext[7:0];
    result.entry_count   = count_ext[2:0];
  end

  assign wr_en   = advance && push_ok;
  assign wr_addr = write_pointer;
  assign rd_addr = advance ? read_pointer_next : read_pointer;

  always_comb begin
    wr_entry.handle       = item.frame_handle;
    wr_entry.capture_time = item.capture_time;
    wr_entry.source_time  = item.source_time;
    wr_entry.fence        = item.fence_value;
    wr_entry.sync         = item.needs_sync;
    wr_entry.pool_index   = item.pool_index;
    wr_entry.generation   = generation;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_pointer <= '0;
      read_pointer  <= '0;
      fill_count    <= '0;
      busy_mask     <= '0;
    end else if (advance) begin
      write_pointer <= write_pointer_next;
      read_pointer  <= read_pointer_next;
      fill_count    <= fill_count_next;
      busy_mask     <= busy_mask_next;
    end
  end

endmodule

### src/frame_ring_with_inflight_mask_core.sv
// Ring of frame descriptors that drops its oldest entry when a push finds it full, with an
// in-flight bit per pool slot. Each request (push, pop, release, clear) yields exactly one
// result carrying the popped descriptor, the in-flight mask and the entry count after the
// request. A request is registered on entry, processed in one pass against the head register
// that always holds the oldest descriptor, and its result is registered on exit, so the block
// takes one request per clock while the result side is not stalled. The user must write the
// generation tag via the configuration channel while no request is pending; not enforced.
module frame_ring_with_inflight_mask_core #(
  parameter int RING_DEPTH = 4,
  parameter int POOL_SLOTS = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  frc_pkg::req_t   req_data,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output frc_pkg::rsp_t   rsp_data,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [63:0]     cfg_data
);

  localparam int PW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CW = $clog2(RING_DEPTH + 1);

  logic              item_valid;
  frc_pkg::req_t     item;
  logic              advance;
  logic [63:0]       generation_tag;
  frc_pkg::rsp_t     result;
  frc_pkg::entry_t   head;
  frc_pkg::entry_t   wr_entry;
  logic              wr_en;
  logic [PW-1:0]     wr_addr;
  logic [PW-1:0]     rd_addr;

  assign advance   = item_valid && (!rsp_valid || !rsp_stall);
  assign req_stall = item_valid && !advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!req_stall) begin
      item_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      item <= req_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      generation_tag <= 64'd0;
    end else if (cfg_valid && cfg_ready) begin
      generation_tag <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp_data <= result;
    end
  end

  frc_ctrl #(
    .RING_DEPTH(RING_DEPTH),
    .POOL_SLOTS(POOL_SLOTS),
    .PW(PW),
    .CW(CW)
  ) u_ctrl (
    .clk(clk),
    .rst(rst),
    .advance(advance),
    .item(item),
    .head(head),
    .generation(generation_tag),
    .result(result),
    .wr_en(wr_en),
    .wr_addr(wr_addr),
    .wr_entry(wr_entry),
    .rd_addr(rd_addr)
  );

  frc_store #(
    .RING_DEPTH(RING_DEPTH),
    .PW(PW)
  ) u_store (
    .clk(clk),
    .wr_en(wr_en),
    .wr_addr(wr_addr),
    .wr_entry(wr_entry),
    .rd_addr(rd_addr),
    .head(head)
  );

endmodule

### tb/frc_checker.sv
module frc_checker #(
  parameter int RING_DEPTH = 4,
  parameter int POOL_SLOTS = 8
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  input  logic           req_stall,
  input  frc_pkg::req_t  req_data,
  input  logic           rsp_valid,
  input  logic           rsp_stall,
  input  frc_pkg::rsp_t  rsp_data,
  input  logic           cfg_valid,
  input  logic           cfg_ready,
  input  logic [63:0]    cfg_data,
  output int             mismatches,
  output int             outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  frc_pkg::entry_t ring_entry [RING_DEPTH];
  int              head_slot;
  int              tail_slot;
  int              held;
  logic [7:0]      busy_slots;
  logic [63:0]     generation_tag;
  frc_pkg::rsp_t   frame_results_due [$];
  frc_pkg::rsp_t   want;

  function automatic logic [7:0] slot_bit(logic signed [3:0] slot);
    if (slot < 0 || int'(slot) >= POOL_SLOTS) begin
      return '0;
    end
    return 8'd1 << int'(slot);
  endfunction

  function automatic frc_pkg::rsp_t step_frame_ring(frc_pkg::req_t r);
    frc_pkg::rsp_t o;
    o = '0;
    o.out_pool_index = frc_pkg::NO_POOL_INDEX;
    case (r.req_type)
      frc_pkg::REQ_PUSH: begin
        if (r.frame_handle != '0) begin
          if (held == RING_DEPTH) begin
            busy_slots &= ~slot_bit(ring_entry[head_slot].pool_index);
            head_slot = (head_slot + 1) % RING_DEPTH;
            held--;
            o.dropped_oldest = 1'b1;
          end
          ring_entry[tail_slot].handle       = r.frame_handle;
          ring_entry[tail_slot].capture_time = r.capture_time;
          ring_entry[tail_slot].source_time  = r.source_time;
          ring_entry[tail_slot].fence        = r.fence_value;
          ring_entry[tail_slot].sync         = r.needs_sync;
          ring_entry[tail_slot].pool_index   = r.pool_index;
          ring_entry[tail_slot].generation   = generation_tag;
          busy_slots |= slot_bit(r.pool_index);
          tail_slot = (tail_slot + 1) % RING_DEPTH;
          held++;
        end
      end
      frc_pkg::REQ_POP: begin
        if (held > 0) begin
          o.pop_valid        = 1'b1;
          o.out_handle       = ring_entry[head_slot].handle;
          o.out_capture_time = ring_entry[head_slot].capture_time;
          o.out_source_time  = ring_entry[head_slot].source_time;
          o.out_fence        = ring_entry[head_slot].fence;
          o.out_sync         = ring_entry[head_slot].sync;
          o.out_pool_index   = ring_entry[head_slot].pool_index;
          o.out_generation   = ring_entry[head_slot].generation;
          head_slot = (head_slot + 1) % RING_DEPTH;
          held--;
        end
      end
      frc_pkg::REQ_RELEASE: begin
        busy_slots &= ~slot_bit(r.pool_index);
      end
      frc_pkg::REQ_CLEAR: begin
        head_slot  = 0;
        tail_slot  = 0;
        held       = 0;
        busy_slots = '0;
      end
    endcase
    o.inflight_mask = busy_slots;
    o.entry_count   = held[2:0];
    return o;
  endfunction

  task automatic check_field(string name, logic [63:0] expected_value, logic [63:0] actual_value);
    if (actual_value !== expected_value) begin
      if (mismatches < 10) begin
        $display("%0t: %s mismatch, expected %h, got %h", $realtime, name, expected_value,
                 actual_value);
      end
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      head_slot      = 0;
      tail_slot      = 0;
      held           = 0;
      busy_slots     = '0;
      generation_tag = '0;
      mismatches     = 0;
      frame_results_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        generation_tag = cfg_data;
      end
      if (rsp_valid && !rsp_stall) begin
        if (frame_results_due.size() == 0) begin
          if (mismatches < 10) begin
            $display("%0t: result with no request outstanding: %h", $realtime, rsp_data);
          end
          mismatches++;
        end else begin
          want = frame_results_due.pop_front();
          check_field("pop_valid", want.pop_valid, rsp_data.pop_valid);
          check_field("out_handle", want.out_handle, rsp_data.out_handle);
          check_field("out_capture_time", want.out_capture_time, rsp_data.out_capture_time);
          check_field("out_source_time", want.out_source_time, rsp_data.out_source_time);
          check_field("out_fence", want.out_fence, rsp_data.out_fence);
          check_field("out_sync", want.out_sync, rsp_data.out_sync);
          check_field("out_pool_index", $unsigned(want.out_pool_index),
                      $unsigned(rsp_data.out_pool_index));
          check_field("out_generation", want.out_generation, rsp_data.out_generation);
          check_field("inflight_mask", want.inflight_mask, rsp_data.inflight_mask);
          check_field("entry_count", want.entry_count, rsp_data.entry_count);
          check_field("dropped_oldest", want.dropped_oldest, rsp_data.dropped_oldest);
        end
      end
      if (req_valid && !req_stall) begin
        frame_results_due.push_back(step_frame_ring(req_data));
      end
    end
    outstanding = frame_results_due.size();
  end

endmodule

### tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 2000;
  localparam int PHASE_COUNT = 6;
  localparam int PHASE_REQUESTS = 305;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          req_valid = 1'b0;
  logic          req_stall;
  frc_pkg::req_t req_data = '0;
  logic          rsp_valid;
  logic          rsp_stall = 1'b0;
  frc_pkg::rsp_t rsp_data;
  logic          cfg_valid = 1'b0;
  logic          cfg_ready;
  logic [63:0]   cfg_data = '0;

  int mismatches;
  int outstanding;
  int quiet_cycles = 0;
  int stall_left = 0;
  int stall_draw;
  bit sender_calm = 1'b0;
  bit receiver_calm = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  frame_ring_with_inflight_mask_core dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  frc_checker u_check (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .req_data    (req_data),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .rsp_data    (rsp_data),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always @(posedge clk) begin
    if (rst) begin
      rsp_stall  <= 1'b0;
      stall_left <= 0;
    end else if (rsp_valid && !rsp_stall) begin
      if ($urandom_range(0, 39) == 0) begin
        receiver_calm = !receiver_calm;
      end
      stall_draw = receiver_calm ? 0 : $urandom_range(0, 14);
      stall_left <= stall_draw;
      rsp_stall  <= (stall_draw != 0);
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      rsp_stall  <= (stall_left > 1);
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [63:0] wide_word();
    return {$urandom, $urandom};
  endfunction

  function automatic frc_pkg::req_t frame_req(logic [1:0] kind, logic [63:0] handle,
                                              logic signed [3:0] slot);
    frc_pkg::req_t r;
    r.req_type     = kind;
    r.frame_handle = handle;
    r.capture_time = 63'(wide_word());
    r.source_time  = 63'(wide_word());
    r.fence_value  = wide_word();
    r.needs_sync   = 1'($urandom);
    r.pool_index   = slot;
    return r;
  endfunction

  function automatic logic signed [3:0] pick_slot();
    int n;
    n = $urandom_range(0, 19);
    if (n < 15) begin
      return 4'($urandom_range(0, 7));
    end
    if (n < 17) begin
      return frc_pkg::NO_POOL_INDEX;
    end
    return 4'($urandom);
  endfunction

  function automatic frc_pkg::req_t random_request();
    int n;
    logic [63:0] handle;
    n = $urandom_range(0, 99);
    case ($urandom_range(0, 15))
      0:       handle = '0;
      1, 2:    handle = 64'($urandom_range(1, 15));
      default: handle = wide_word();
    endcase
    if (n < 45) begin
      return frame_req(frc_pkg::REQ_PUSH, handle, pick_slot());
    end
    if (n < 78) begin
      return frame_req(frc_pkg::REQ_POP, handle, 4'($urandom));
    end
    if (n < 95) begin
      return frame_req(frc_pkg::REQ_RELEASE, handle, pick_slot());
    end
    return frame_req(frc_pkg::REQ_CLEAR, handle, 4'($urandom));
  endfunction

  task automatic send_req(input frc_pkg::req_t r);
    int gap;
    if ($urandom_range(0, 49) == 0) begin
      sender_calm = !sender_calm;
    end
    gap = sender_calm ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_data  <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  task automatic settle();
    req_valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_generation(input logic [63:0] tag);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= tag;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    frc_pkg::req_t r;
    int            done;
    logic [63:0]   tags [PHASE_COUNT];

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    write_generation('1);
    send_req(frame_req(frc_pkg::REQ_POP, wide_word(), frc_pkg::NO_POOL_INDEX));
    send_req(frame_req(frc_pkg::REQ_PUSH, '0, 4'sd3));
    r = frame_req(frc_pkg::REQ_PUSH, '1, 4'sd7);
    r.capture_time = '1;
    r.source_time  = '1;
    r.fence_value  = '1;
    r.needs_sync   = 1'b1;
    send_req(r);
    r = frame_req(frc_pkg::REQ_PUSH, 64'd1, 4'sd0);
    r.capture_time = '0;
    r.source_time  = '0;
    r.fence_value  = '0;
    r.needs_sync   = 1'b0;
    send_req(r);
    send_req(frame_req(frc_pkg::REQ_PUSH, wide_word(), frc_pkg::NO_POOL_INDEX));
    send_req(frame_req(frc_pkg::REQ_PUSH, wide_word(), 4'sb1000));
    send_req(frame_req(frc_pkg::REQ_PUSH, wide_word(), 4'sd2));
    send_req(frame_req(frc_pkg::REQ_PUSH, wide_word(), 4'sd5));
    send_req(frame_req(frc_pkg::REQ_RELEASE, wide_word(), 4'sd2));
    send_req(frame_req(frc_pkg::REQ_RELEASE, wide_word(), frc_pkg::NO_POOL_INDEX));
    send_req(frame_req(frc_pkg::REQ_RELEASE, wide_word(), 4'sb1101));
    send_req(frame_req(frc_pkg::REQ_POP, wide_word(), 4'sd1));
    send_req(frame_req(frc_pkg::REQ_POP, wide_word(), 4'sd1));
    write_generation('0);
    send_req(frame_req(frc_pkg::REQ_PUSH, wide_word(), 4'sd6));
    send_req(frame_req(frc_pkg::REQ_CLEAR, wide_word(), 4'sd6));
    send_req(frame_req(frc_pkg::REQ_POP, wide_word(), 4'sd0));
    send_req(frame_req(frc_pkg::REQ_RELEASE, wide_word(), 4'sd6));
    send_req(frame_req(frc_pkg::REQ_PUSH, wide_word(), 4'sd4));
    send_req(frame_req(frc_pkg::REQ_POP, wide_word(), 4'sd4));
    send_req(frame_req(frc_pkg::REQ_POP, wide_word(), 4'sd4));

    tags = '{64'd0, '1, wide_word(), 64'd1, 64'h8000_0000_0000_0000, wide_word()};
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      write_generation(tags[phase]);
      done = 0;
      while (done < PHASE_REQUESTS) begin
        r = random_request();
        send_req(r);
        if (!(r.req_type == frc_pkg::REQ_PUSH && r.frame_handle == '0)) begin
          done++;
        end
      end
    end

    settle();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### frame_ring_with_inflight_mask_core.f
src/frc_pkg.sv
src/frc_store.sv
src/frc_ctrl.sv
src/frame_ring_with_inflight_mask_core.sv
tb/frc_checker.sv
tb/tb.sv
